// ===== design/surface_coulomb_source_sum_defines.svh =====
// Assertion macros for the surface Coulomb source sum top level.
`ifndef SURFACE_COULOMB_SOURCE_SUM_DEFINES_SVH
`define SURFACE_COULOMB_SOURCE_SUM_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked property, disabled while reset is asserted.
`define SCSS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("surface_coulomb_source_sum: check failed");
// Checked property that also holds across reset.
`define SCSS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("surface_coulomb_source_sum: check failed");
`else
`define SCSS_ASSERT(lbl, prop)
`define SCSS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/scss_pkg.sv =====
// Package with the shared widths, constants and status types of the source sum block.
package scss_pkg;

  // Shared multiplier: operands split into two halves.
  localparam int MUL_W  = 54;
  localparam int MUL_HALF = 27;
  localparam int PROD_W = 108;

  // Shared divider: divisor width and quotient width.
  localparam int DEN_W = 66;
  localparam int QUO_W = 53;

  // Accumulator and result widths.
  localparam int ACC_W = 62;
  localparam int OUT_W = 48;

  // round(2^32 / (4*pi)).
  localparam logic [28:0] INV_4PI_Q32 = 29'd341782638;

  // Largest magnitude a single term may take.
  localparam logic [QUO_W-1:0] TERM_CAP = 53'h10_0000_0000_0000;

  // Running sums stay within plus or minus 2^60.
  localparam logic signed [ACC_W-1:0] ACC_CAP = 62'sh1000_0000_0000_0000;

  // Signed 48 bit result range.
  localparam logic signed [ACC_W-1:0] OUT_MAX = 62'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -62'sh8000_0000_0000;

  // Status of the shared divider.
  typedef struct packed {
    logic done;
    logic capped;
  } scss_div_stat_t;

endpackage

// ===== design/scss_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module scss_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/scss_mul.sv =====
// Shared unsigned multiplier, four half-width partial products accumulated in sequence.
module scss_mul
  import scss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic              done,
  output logic [PROD_W-1:0] p
);

  logic [MUL_W-1:0]    a_r, b_r;
  logic [PROD_W-1:0]   acc_r;
  logic [1:0]          step_r;
  logic                busy_r, done_r;
  logic [MUL_HALF-1:0] a_part, b_part;
  logic [MUL_W-1:0]    pp;
  logic [PROD_W-1:0]   addend;

  // Select the halves for this step and align the partial product.
  always_comb begin
    a_part = step_r[1] ? a_r[MUL_W-1:MUL_HALF] : a_r[MUL_HALF-1:0];
    b_part = step_r[0] ? b_r[MUL_W-1:MUL_HALF] : b_r[MUL_HALF-1:0];
    pp     = a_part * b_part;
    case (step_r)
      2'd0:    addend = PROD_W'(pp);
      2'd3:    addend = PROD_W'(pp) << (2 * MUL_HALF);
      default: addend = PROD_W'(pp) << MUL_HALF;
    endcase
  end

  // Sequence the partial products.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        step_r <= 2'd0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r  <= acc_r + addend;
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ===== design/scss_div.sv =====
// Shared restoring divider, one quotient bit per cycle, result clamped to the term cap.
module scss_div
  import scss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] num,
  input  logic [DEN_W-1:0]  den,
  output logic [QUO_W-1:0]  quo,
  output scss_div_stat_t    stat
);

  logic [DEN_W-1:0]         rem_r, den_r;
  logic [QUO_W-1:0]         nlo_r, quo_r;
  logic [5:0]               cnt_r;
  logic                     busy_r, done_r, capped_r;
  logic [PROD_W-QUO_W-1:0]  hi;
  logic [DEN_W:0]           sh, diff;
  logic                     qbit;
  logic [QUO_W-1:0]         qn;

  // Trial subtraction for the current quotient bit.
  always_comb begin
    hi   = num[PROD_W-1:QUO_W];
    sh   = {rem_r, nlo_r[QUO_W-1]};
    diff = sh - {1'b0, den_r};
    qbit = (sh >= {1'b0, den_r});
    qn   = {quo_r[QUO_W-2:0], qbit};
  end

  // A quotient of 2^53 or more is seen at the start from the upper bits alone.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      capped_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r    <= den;
        capped_r <= 1'b0;
        if (DEN_W'(hi) >= den) begin
          quo_r    <= TERM_CAP;
          capped_r <= 1'b1;
          done_r   <= 1'b1;
        end else begin
          rem_r  <= DEN_W'(hi);
          nlo_r  <= num[QUO_W-1:0];
          quo_r  <= '0;
          cnt_r  <= 6'(QUO_W);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= qbit ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        nlo_r <= {nlo_r[QUO_W-2:0], 1'b0};
        cnt_r <= cnt_r - 6'd1;
        quo_r <= qn;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (qn > TERM_CAP) begin
            quo_r    <= TERM_CAP;
            capped_r <= 1'b1;
          end
        end
      end
    end
  end

  assign quo         = quo_r;
  assign stat.done   = done_r;
  assign stat.capped = capped_r;

endmodule

// ===== design/surface_coulomb_source_sum.sv =====
// Top level of the direct-sum Coulomb source term block for surface points.
//
// Input channel (in_*): a transfer with in_tuser low loads one atom (slot, position,
// charge) into the atom memory. A transfer with in_tuser high is a
// surface point (position, unit normal); in_tlast marks the last point of a batch.
// For each point the block walks the first atom_count atoms, at most MAX_ATOMS, and
// returns one transfer on the result channel (out_*) with both sums, the fault and
// saturation flags in out_tuser and the echoed batch marker on out_tlast.
// Points are processed one at a time. Each atom takes one memory read, nine products on
// the shared multiplier, a 34 step square root and two 53 step divisions on the shared
// divider; a division that clamps at its start skips its steps, and a coincident atom
// stops after the first seven products.
// A finished result waits in the output register; the next item is accepted while it
// waits, and only a second result stalls until out_tready takes the first.
// Reset clears the control logic and the registers (atom_count 0, inv_eps_solute 1.0);
// the atom memory is not cleared and must be loaded before it is summed.
// Registers on the APB port: atom_count at 0x0, inv_eps_solute at 0x4.
`include "surface_coulomb_source_sum_defines.svh"
module surface_coulomb_source_sum
  import scss_pkg::*;
#(
  parameter int MAX_ATOMS = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel
  input  logic         in_tvalid,
  output logic         in_tready,
  // atom_slot[9:0], pos_x[41:10], pos_y[73:42], pos_z[105:74], atom_charge[121:106],
  // norm_x[137:122], norm_y[153:138], norm_z[169:154], zero fill[175:170]
  input  logic [175:0] in_tdata,
  // kind[0]
  input  logic         in_tuser,
  input  logic         in_tlast,
  // Result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  // potential_sum[47:0], normal_derivative_sum[95:48]
  output logic [95:0]  out_tdata,
  // zero_distance_fault[0], saturated[1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  // Configuration port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int RAM_W = 112;
  localparam logic [16:0] MAX_ATOMS_V = 17'(MAX_ATOMS);

  localparam logic KIND_ATOM = 1'b0;
  localparam logic REG_ATOM_COUNT = 1'b0;
  localparam logic REG_INV_EPS = 1'b1;

  localparam logic [2:0] OP_SQ_X  = 3'd0;
  localparam logic [2:0] OP_SQ_Y  = 3'd1;
  localparam logic [2:0] OP_SQ_Z  = 3'd2;
  localparam logic [2:0] OP_DOT_X = 3'd3;
  localparam logic [2:0] OP_DOT_Y = 3'd4;
  localparam logic [2:0] OP_DOT_Z = 3'd5;
  localparam logic [2:0] OP_QEPS  = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_DIFF, ST_MUL, ST_MWAIT, ST_CHECK, ST_SQRT, ST_KSTART,
    ST_KMUL, ST_DIV0, ST_TSTART, ST_TMUL, ST_DIV1, ST_ACC, ST_ADV, ST_FIN
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [10:0] atom_count_r;
  logic [23:0] inv_eps_r;
  logic        cfg_wr;

  // Point and per-atom working registers
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] nx_r, ny_r, nz_r;
  logic               last_r;
  logic [CW-1:0]      n_r, idx_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic signed [15:0] q_r;
  logic [2:0]         op_r;
  logic [DEN_W-1:0]   s_r;
  logic signed [49:0] dot_r;
  logic [38:0]        qe_r;
  logic [QUO_W-1:0]   t0_r;
  logic signed [ACC_W-1:0] acc0_r, acc1_r;
  logic               fault_r, sat_r;

  // Square root registers
  logic [67:0] sq_r;
  logic [35:0] srem_r;
  logic [33:0] root_r;
  logic [5:0]  scnt_r;

  // Output register
  logic             out_valid_r;
  logic [OUT_W-1:0] out_pot_r, out_nd_r;
  logic             out_fault_r, out_sat_r, out_last_r;

  // Input field views
  logic [9:0]         in_slot;
  logic signed [31:0] in_px, in_py, in_pz;
  logic signed [15:0] in_q, in_nx, in_ny, in_nz;
  logic               in_acc;
  logic [16:0]        slot_ext, cnt_lim;

  // Memory signals
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;

  // Arithmetic units
  logic                mul_start, div_start, mul_done;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [DEN_W-1:0]    div_den;
  logic [QUO_W-1:0]    div_quo;
  scss_div_stat_t      div_stat;

  // Combinational helpers
  logic [32:0] dxm, dym, dzm;
  logic [15:0] nxm, nym, nzm, qm;
  logic [49:0] dotm, dot_term;
  logic        term_neg;
  logic [37:0] s_cur, s_trial;
  logic        s_take;
  logic [ACC_W:0] add0, add1;
  logic [CW-1:0]  idx_inc;

  // Field unpacking
  assign in_slot = in_tdata[9:0];
  assign in_px   = in_tdata[41:10];
  assign in_py   = in_tdata[73:42];
  assign in_pz   = in_tdata[105:74];
  assign in_q    = in_tdata[121:106];
  assign in_nx   = in_tdata[137:122];
  assign in_ny   = in_tdata[153:138];
  assign in_nz   = in_tdata[169:154];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_ext  = 17'(in_slot);
  assign cnt_lim   = (17'(atom_count_r) > MAX_ATOMS_V) ? MAX_ATOMS_V : 17'(atom_count_r);
  assign idx_inc   = idx_r + CW'(1);

  // Atom loads write the memory directly; slots past the table are dropped.
  assign ram_we    = in_acc && (in_tuser == KIND_ATOM) && (slot_ext < MAX_ATOMS_V);
  assign ram_waddr = slot_ext[AW-1:0];
  assign ram_wdata = {in_q, in_pz, in_py, in_px};
  assign ram_raddr = idx_r[AW-1:0];

  scss_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_ATOMS),
    .AW    (AW)
  ) u_atom_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Magnitudes of the differences, normal components, charge and dot product.
  always_comb begin
    dxm  = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
    dym  = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
    dzm  = dz_r[32] ? 33'(-dz_r) : 33'(dz_r);
    nxm  = nx_r[15] ? 16'(-nx_r) : 16'(nx_r);
    nym  = ny_r[15] ? 16'(-ny_r) : 16'(ny_r);
    nzm  = nz_r[15] ? 16'(-nz_r) : 16'(nz_r);
    qm   = q_r[15] ? 16'(-q_r) : 16'(q_r);
    dotm = dot_r[49] ? 50'(-dot_r) : 50'(dot_r);
  end

  // Operands of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        case (op_r)
          OP_SQ_X: begin
            mul_a = MUL_W'(dxm);
            mul_b = MUL_W'(dxm);
          end
          OP_SQ_Y: begin
            mul_a = MUL_W'(dym);
            mul_b = MUL_W'(dym);
          end
          OP_SQ_Z: begin
            mul_a = MUL_W'(dzm);
            mul_b = MUL_W'(dzm);
          end
          OP_DOT_X: begin
            mul_a = MUL_W'(nxm);
            mul_b = MUL_W'(dxm);
          end
          OP_DOT_Y: begin
            mul_a = MUL_W'(nym);
            mul_b = MUL_W'(dym);
          end
          OP_DOT_Z: begin
            mul_a = MUL_W'(nzm);
            mul_b = MUL_W'(dzm);
          end
          OP_QEPS: begin
            mul_a = MUL_W'(qm);
            mul_b = MUL_W'(inv_eps_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      ST_KSTART: begin
        mul_a = MUL_W'(qe_r);
        mul_b = MUL_W'(INV_4PI_Q32);
      end
      ST_TSTART: begin
        mul_a = MUL_W'(t0_r);
        mul_b = MUL_W'({dotm, 2'b00});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sign of a dot product term.
  always_comb begin
    case (op_r)
      OP_DOT_X: term_neg = nx_r[15] ^ dx_r[32];
      OP_DOT_Y: term_neg = ny_r[15] ^ dy_r[32];
      OP_DOT_Z: term_neg = nz_r[15] ^ dz_r[32];
      default:  term_neg = 1'b0;
    endcase
    dot_term = 50'(mul_p[47:0]);
  end

  assign mul_start = (state_r == ST_MUL) || (state_r == ST_KSTART) || (state_r == ST_TSTART);
  assign div_start = ((state_r == ST_KMUL) || (state_r == ST_TMUL)) && mul_done;
  assign div_den   = (state_r == ST_KMUL) ? DEN_W'({root_r, 16'b0}) : s_r;

  scss_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  scss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_p),
    .den   (div_den),
    .quo   (div_quo),
    .stat  (div_stat)
  );

  // One square root digit: bring down two bits and try the next root bit.
  always_comb begin
    s_cur   = {srem_r, sq_r[67:66]};
    s_trial = 38'({root_r, 2'b01});
    s_take  = (s_cur >= s_trial);
  end

  // Add a signed term to a running sum and clamp to plus or minus 2^60.
  function automatic logic [ACC_W:0] acc_add(input logic signed [ACC_W-1:0] acc,
                                             input logic [QUO_W-1:0] tmag,
                                             input logic neg);
    logic signed [ACC_W:0] t;
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] cap;
    begin
      t   = $signed((ACC_W+1)'(tmag));
      cap = (ACC_W+1)'(ACC_CAP);
      if (neg) begin
        t = -t;
      end
      s = $signed({acc[ACC_W-1], acc}) + t;
      if (s > cap) begin
        acc_add = {1'b1, ACC_CAP};
      end else if (s < -cap) begin
        acc_add = {1'b1, -ACC_CAP};
      end else begin
        acc_add = {1'b0, s[ACC_W-1:0]};
      end
    end
  endfunction

  assign add0 = acc_add(acc0_r, t0_r, q_r[15]);
  assign add1 = acc_add(acc1_r, div_quo, q_r[15] ^ dot_r[49]);

  // Configuration writes.
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[2])
      REG_ATOM_COUNT: cfg_prdata = 32'(atom_count_r);
      REG_INV_EPS:    cfg_prdata = 32'(inv_eps_r);
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atom_count_r <= '0;
      inv_eps_r    <= 24'd65536;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ATOM_COUNT: atom_count_r <= cfg_pwdata[10:0];
        REG_INV_EPS:    inv_eps_r    <= cfg_pwdata[23:0];
        default:        atom_count_r <= atom_count_r;
      endcase
    end
  end

  // Sequencer for one surface point, together with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      acc0_r      <= '0;
      acc1_r      <= '0;
    end else begin
      // The finishing state reloads the output register itself.
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser != KIND_ATOM)) begin
            px_r    <= in_px;
            py_r    <= in_py;
            pz_r    <= in_pz;
            nx_r    <= in_nx;
            ny_r    <= in_ny;
            nz_r    <= in_nz;
            last_r  <= in_tlast;
            n_r     <= cnt_lim[CW-1:0];
            idx_r   <= '0;
            acc0_r  <= '0;
            acc1_r  <= '0;
            fault_r <= 1'b0;
            sat_r   <= 1'b0;
            state_r <= (cnt_lim == 17'd0) ? ST_FIN : ST_RD;
          end
        end
        ST_RD: begin
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          dx_r    <= {ram_rdata[31], ram_rdata[31:0]} - {px_r[31], px_r};
          dy_r    <= {ram_rdata[63], ram_rdata[63:32]} - {py_r[31], py_r};
          dz_r    <= {ram_rdata[95], ram_rdata[95:64]} - {pz_r[31], pz_r};
          q_r     <= ram_rdata[111:96];
          s_r     <= '0;
          dot_r   <= '0;
          op_r    <= OP_SQ_X;
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_MWAIT;
        end
        ST_MWAIT: begin
          if (mul_done) begin
            if (op_r <= OP_SQ_Z) begin
              s_r <= s_r + mul_p[DEN_W-1:0];
            end else if (op_r == OP_QEPS) begin
              qe_r <= mul_p[38:0];
            end else begin
              dot_r <= term_neg ? dot_r - $signed(dot_term) : dot_r + $signed(dot_term);
            end
            if (op_r == OP_QEPS) begin
              state_r <= ST_CHECK;
            end else begin
              op_r    <= op_r + 3'd1;
              state_r <= ST_MUL;
            end
          end
        end
        ST_CHECK: begin
          if (s_r == '0) begin
            fault_r <= 1'b1;
            state_r <= ST_ADV;
          end else begin
            sq_r    <= 68'(s_r);
            srem_r  <= '0;
            root_r  <= '0;
            scnt_r  <= 6'd34;
            state_r <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          srem_r <= s_take ? 36'(s_cur - s_trial) : s_cur[35:0];
          root_r <= {root_r[32:0], s_take};
          sq_r   <= {sq_r[65:0], 2'b00};
          scnt_r <= scnt_r - 6'd1;
          if (scnt_r == 6'd1) begin
            state_r <= ST_KSTART;
          end
        end
        ST_KSTART: begin
          state_r <= ST_KMUL;
        end
        ST_KMUL: begin
          if (mul_done) begin
            state_r <= ST_DIV0;
          end
        end
        ST_DIV0: begin
          if (div_stat.done) begin
            t0_r    <= div_quo;
            sat_r   <= sat_r | div_stat.capped;
            state_r <= ST_TSTART;
          end
        end
        ST_TSTART: begin
          state_r <= ST_TMUL;
        end
        ST_TMUL: begin
          if (mul_done) begin
            state_r <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_stat.done) begin
            sat_r   <= sat_r | div_stat.capped;
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          acc0_r  <= add0[ACC_W-1:0];
          acc1_r  <= add1[ACC_W-1:0];
          sat_r   <= sat_r | add0[ACC_W] | add1[ACC_W];
          state_r <= ST_ADV;
        end
        ST_ADV: begin
          idx_r   <= idx_inc;
          state_r <= (idx_inc == n_r) ? ST_FIN : ST_RD;
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_fault_r <= fault_r;
            out_last_r  <= last_r;
            out_sat_r   <= sat_r || (acc0_r > OUT_MAX) || (acc0_r < OUT_MIN)
                           || (acc1_r > OUT_MAX) || (acc1_r < OUT_MIN);
            out_pot_r   <= (acc0_r > OUT_MAX) ? OUT_MAX[OUT_W-1:0] :
                           (acc0_r < OUT_MIN) ? OUT_MIN[OUT_W-1:0] : acc0_r[OUT_W-1:0];
            out_nd_r    <= (acc1_r > OUT_MAX) ? OUT_MAX[OUT_W-1:0] :
                           (acc1_r < OUT_MIN) ? OUT_MIN[OUT_W-1:0] : acc1_r[OUT_W-1:0];
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_nd_r, out_pot_r};
  assign out_tuser  = {out_sat_r, out_fault_r};
  assign out_tlast  = out_last_r;

  // The multiplier and the divider are never started together.
  `SCSS_ASSERT(a_single_start, !(mul_start && div_start))
  // The potential running sum stays inside its clamp.
  `SCSS_ASSERT(a_acc_range, (acc0_r <= ACC_CAP) && (acc0_r >= -ACC_CAP))
  // A finished point waits while the previous result is still held.
  `SCSS_ASSERT(a_fin_hold, (state_r == ST_FIN && out_valid_r && !out_tready) |=> (state_r == ST_FIN))
  // The idle state is not left without a valid input.
  `SCSS_ASSERT(a_leave_idle, (state_r == ST_IDLE && !in_tvalid) |=> (state_r == ST_IDLE))

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the surface Coulomb source sum block.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  localparam int FINAL_ATOMS = 64;
  localparam int IDLE_LIMIT = 700000;
  localparam logic [2:0] ADDR_ATOM_COUNT = 3'd0;
  localparam logic [2:0] ADDR_INV_EPS = 3'd4;
  localparam bit KIND_ATOM = 1'b0;
  localparam bit KIND_POINT = 1'b1;

  typedef struct {
    bit          kind;
    bit [9:0]    slot;
    int          px, py, pz;
    shortint     charge, nx, ny, nz;
    bit          last;
  } item_t;

  typedef struct {
    logic [47:0] pot;
    logic [47:0] deriv;
    bit          fault;
    bit          sat;
    bit          last;
  } sums_t;

  // Scoreboard: its own copy of the atom table and registers, and the
  // queue of sums still owed by the block.
  class source_sum_board;
    int          tab_x[TABLE_DEPTH];
    int          tab_y[TABLE_DEPTH];
    int          tab_z[TABLE_DEPTH];
    shortint     tab_q[TABLE_DEPTH];
    int unsigned atom_count = 0;
    int unsigned inv_eps = 65536;
    sums_t       owed[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          faults_seen = 0;
    int          sats_seen = 0;

    function automatic longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic logic [47:0] clamp_out(longint v, ref bit sat);
      if (v > 64'sh7FFF_FFFF_FFFF) begin
        sat = 1;
        return 48'h7FFF_FFFF_FFFF;
      end
      if (v < -64'sh8000_0000_0000) begin
        sat = 1;
        return 48'h8000_0000_0000;
      end
      return v[47:0];
    endfunction

    // Note an accepted input: a load updates the table, a point owes a result.
    function automatic void note_input(item_t it);
      longint       dx, dy, dz, qe, dot, acc0, acc1, cap_acc;
      logic [127:0] sq, r, c, absqe, num, q0, q1, term_cap;
      int unsigned  n;
      bit           fault, sat;
      sums_t        s;
      if (it.kind == KIND_ATOM) begin
        tab_x[it.slot] = it.px;
        tab_y[it.slot] = it.py;
        tab_z[it.slot] = it.pz;
        tab_q[it.slot] = it.charge;
        return;
      end
      acc0 = 0;
      acc1 = 0;
      fault = 0;
      sat = 0;
      cap_acc = 64'sd1 <<< 60;
      term_cap = 128'd1 << 52;
      n = atom_count < TABLE_DEPTH ? atom_count : TABLE_DEPTH;
      for (int i = 0; i < n; i++) begin
        dx = longint'(tab_x[i]) - longint'(it.px);
        dy = longint'(tab_y[i]) - longint'(it.py);
        dz = longint'(tab_z[i]) - longint'(it.pz);
        qe = longint'(tab_q[i]) * longint'(inv_eps);
        dot = longint'(it.nx) * dx + longint'(it.ny) * dy + longint'(it.nz) * dz;
        sq = 128'(magn(dx)) * 128'(magn(dx)) + 128'(magn(dy)) * 128'(magn(dy))
           + 128'(magn(dz)) * 128'(magn(dz));
        if (sq == 0) begin
          fault = 1;
          continue;
        end
        // Integer square root, one bit per step from the top.
        r = 0;
        for (int b = 33; b >= 0; b--) begin
          c = r | (128'd1 << b);
          if (sq >= c * c) r = c;
        end
        absqe = 128'(magn(qe));
        num = absqe * 128'd341782638;
        q0 = num / (r << 16);
        if (q0 > term_cap) begin
          q0 = term_cap;
          sat = 1;
        end
        num = q0 * 128'(magn(dot)) * 128'd4;
        q1 = num / sq;
        if (q1 > term_cap) begin
          q1 = term_cap;
          sat = 1;
        end
        acc0 += (qe < 0) ? -longint'(q0[63:0]) : longint'(q0[63:0]);
        acc1 += ((qe < 0) != (dot < 0)) ? -longint'(q1[63:0]) : longint'(q1[63:0]);
        if (acc0 > cap_acc) begin acc0 = cap_acc; sat = 1; end
        if (acc0 < -cap_acc) begin acc0 = -cap_acc; sat = 1; end
        if (acc1 > cap_acc) begin acc1 = cap_acc; sat = 1; end
        if (acc1 < -cap_acc) begin acc1 = -cap_acc; sat = 1; end
      end
      s.pot = clamp_out(acc0, sat);
      s.deriv = clamp_out(acc1, sat);
      s.fault = fault;
      s.sat = sat;
      s.last = it.last;
      owed.insert(owed.size(), s);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // Check one result transfer against the oldest owed sums.
    task check_result(logic [95:0] data, logic [1:0] flags, logic lst);
      sums_t w;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result", {32'd0, data[31:0]}, 64'd0);
        return;
      end
      w = owed.pop_front();
      results_seen++;
      if (w.fault) faults_seen++;
      if (w.sat) sats_seen++;
      if (data[47:0] !== w.pot) report_mismatch("potential_sum", data[47:0], w.pot);
      if (data[95:48] !== w.deriv)
        report_mismatch("normal_derivative_sum", data[95:48], w.deriv);
      if (flags[0] !== w.fault) report_mismatch("zero_distance_fault", flags[0], w.fault);
      if (flags[1] !== w.sat) report_mismatch("saturated", flags[1], w.sat);
      if (lst !== w.last) report_mismatch("last_point_out", lst, w.last);
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid, in_tready, in_tuser, in_tlast;
  logic [175:0] in_tdata;
  logic         out_tvalid, out_tready, out_tlast;
  logic [95:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata, cfg_prdata;

  source_sum_board board;
  bit          loaded[TABLE_DEPTH];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_request = 0;
  int          idle_cycles = 0;
  int          items_sent = 0;

  surface_coulomb_source_sum dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  always @(posedge clk) begin
    static int hold_left = 0;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (hold_request) begin
        hold_left = 6000;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", idle_cycles);
      $display("** surface_coulomb_source_sum: FAILED **");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer; valid stays high afterwards.
  task send_item(item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= it.kind;
    in_tlast <= it.last;
    in_tdata <= {6'd0, it.nz, it.ny, it.nx, it.charge, it.pz, it.py, it.px, it.slot};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(it);
    items_sent++;
    if (it.kind == KIND_ATOM) loaded[it.slot] = 1;
  endtask

  // Wait until every owed result has arrived, with the input idle.
  task drain;
    in_tvalid <= 0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(logic [2:0] addr, logic [31:0] value);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= addr;
    cfg_pwdata <= value;
    cfg_penable <= 0;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (addr == ADDR_ATOM_COUNT) board.atom_count = value[10:0];
    else if (addr == ADDR_INV_EPS) board.inv_eps = value[23:0];
    @(posedge clk);
  endtask

  function automatic item_t atom_item(int slot, int x, int y, int z, int q);
    item_t it;
    it = '{default: 0};
    it.kind = KIND_ATOM;
    it.slot = 10'(slot);
    it.px = x; it.py = y; it.pz = z;
    it.charge = 16'(q);
    it.nx = 16'($urandom); it.ny = 16'($urandom); it.nz = 16'($urandom);
    it.last = 1'($urandom);
    return it;
  endfunction

  function automatic item_t point_item(int x, int y, int z, int nx, int ny, int nz, bit lst);
    item_t it;
    it.kind = KIND_POINT;
    it.slot = 10'($urandom);
    it.charge = 16'($urandom);
    it.px = x; it.py = y; it.pz = z;
    it.nx = 16'(nx); it.ny = 16'(ny); it.nz = 16'(nz);
    it.last = lst;
    return it;
  endfunction

  function automatic int rand_norm();
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic int rand_offset();
    case ($urandom_range(3))
      0: return 0;
      1: return int'($urandom_range(32)) - 16;
      2: return int'($urandom_range(8192)) - 4096;
      default: return int'($urandom_range(2097152)) - 1048576;
    endcase
  endfunction

  // Load any slot below the summed count that has never been written.
  task fill_table(int count);
    for (int i = 0; i < count && i < TABLE_DEPTH; i++)
      if (!loaded[i]) send_item(atom_item(i, $urandom, $urandom, $urandom, $urandom));
  endtask

  // One random item: mostly points near loaded atoms, some reloads and noise.
  task random_item(int count);
    int s;
    item_t it;
    if ($urandom_range(99) < 25) begin
      s = ($urandom_range(99) < 75) ? $urandom_range(count - 1) : $urandom_range(1023);
      send_item(atom_item(s, $urandom, $urandom, $urandom, $urandom));
    end else if ($urandom_range(99) < 70) begin
      s = $urandom_range(count - 1);
      it = point_item(board.tab_x[s] + rand_offset(), board.tab_y[s] + rand_offset(),
                      board.tab_z[s] + rand_offset(), rand_norm(), rand_norm(), rand_norm(),
                      $urandom_range(7) == 0);
      send_item(it);
    end else begin
      send_item(point_item($urandom, $urandom, $urandom, rand_norm(), rand_norm(),
                           rand_norm(), 1'($urandom)));
    end
  endtask

  initial begin
    int counts[3];
    int count;
    board = new();
    rst_n <= 0;
    in_tvalid <= 0;
    in_tuser <= 0;
    in_tlast <= 0;
    in_tdata <= '0;
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty sum, extreme atoms, coincident point, huge terms.
    send_item(point_item(32'sh7FFF_FFFF, 0, -1, 16384, -16384, 0, 1));
    drain();
    send_item(atom_item(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32767));
    send_item(atom_item(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -32768));
    send_item(atom_item(2, 65536, -65536, 131072, 256));
    send_item(atom_item(3, 0, 0, 0, -256));
    drain();
    write_reg(ADDR_ATOM_COUNT, 4);
    send_item(point_item(65536, -65536, 131072, 16384, 0, 0, 0));
    send_item(point_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFE, 0, 0, -16384, 0));
    send_item(point_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0001, 0, 16384, 0, 1));
    send_item(point_item(1, 0, 0, -16384, 0, 0, 0));
    drain();
    write_reg(ADDR_INV_EPS, 24'hFF_FFFF);
    send_item(point_item(32'sh7FFF_FFFE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16384, 0, 0, 1));
    send_item(point_item(32'sh8000_0001, 32'sh8000_0000, 32'sh8000_0000, -16384, 0, 0, 0));
    drain();
    write_reg(ADDR_INV_EPS, 0);
    send_item(point_item(0, 0, 1, 0, 0, 16384, 1));
    drain();

    // Random phases under three idling patterns; a long receiver hold in the first.
    counts = '{3, 8, 5};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 72 : 0;
      recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 30 : 0;
      count = counts[ph];
      fill_table(count);
      drain();
      write_reg(ADDR_ATOM_COUNT, count);
      write_reg(ADDR_INV_EPS, (ph == 0) ? 24'hFF_FFFF : (ph == 1) ? $urandom_range(1 << 24) : 1);
      for (int k = 0; k < 170; k++) begin
        if (ph == 0 && k == 60) hold_request = 1;
        random_item(count);
      end
      drain();
    end

    // A larger block of near-coincident atoms with the strongest charge.
    recv_idle_pct = 20;
    for (int i = 0; i < FINAL_ATOMS; i++) send_item(atom_item(i, 1, 0, 0, 32767));
    drain();
    write_reg(ADDR_INV_EPS, 24'hFF_FFFF);
    write_reg(ADDR_ATOM_COUNT, FINAL_ATOMS);
    send_item(point_item(0, 0, 0, 16384, 0, 0, 1));
    drain();
    repeat (200) @(posedge clk);

    $display("%0d items sent, %0d results checked (%0d with a coincident atom, %0d saturated)",
             items_sent, board.results_seen, board.faults_seen, board.sats_seen);
    $display("covered empty, small and medium atom tables under three stall patterns");
    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("** surface_coulomb_source_sum: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches, board.owed.size());
      $display("** surface_coulomb_source_sum: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/scss_pkg.sv
design/scss_ram.sv
design/scss_mul.sv
design/scss_div.sv
design/surface_coulomb_source_sum.sv
test/testbench.sv
